@@ src/hierarchical_tree_lock_manager_defines.svh @@
// Assertion macros for the tree lock manager sources.
`ifndef HIERARCHICAL_TREE_LOCK_MANAGER_DEFINES_SVH
`define HIERARCHICAL_TREE_LOCK_MANAGER_DEFINES_SVH
`ifndef SYNTH
`define HTLM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tree lock manager check failed");
`define HTLM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tree lock manager reset check failed");
`else
`define HTLM_ASSERT_RST(lbl, prop)
`define HTLM_ASSERT(lbl, prop)
`endif
`endif

@@ src/htlm_pkg.sv @@
package htlm_pkg;

  // Fixed field and register widths.
  localparam int FUNC_W    = 2;
  localparam int NODE_W    = 10;
  localparam int USER_W    = 32;
  localparam int CNT_CFG_W = 11;
  localparam int BR_CFG_W  = 5;
  localparam int CFG_IDX_W = 2;

  // Default sizing of the node store.
  localparam int MAX_NODES_DEF  = 1024;
  localparam int MAX_BRANCH_DEF = 16;

  // Register reset values.
  localparam logic [CNT_CFG_W-1:0] RESET_NODE_COUNT = 11'd1024;
  localparam logic [BR_CFG_W-1:0]  RESET_BRANCHING  = 5'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRANCHING  = 2'd1;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOCK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNLOCK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPGRADE = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_NODE,
    S_ANC,
    S_DIV,
    S_ANCD,
    S_LVL,
    S_SUB
  } state_t;

endpackage

@@ src/hierarchical_tree_lock_manager.sv @@
// Sequence: unlock reads the node and answers; lock and upgrade walk the ancestor chain
// (a divide per ancestor, a plain decrement when branching is 1) and then the subtree at
// one node per cycle within a level; upgrade walks the subtree twice. Out of range: refused.
// Throughput: one request at a time; the next start is taken in the result strobe cycle.
// Reset and every write to the node count or branching register start a clearing pass.
// Results cannot be stalled by the receiver.
`include "hierarchical_tree_lock_manager_defines.svh"
module hierarchical_tree_lock_manager #(
  parameter int MAX_NODES  = htlm_pkg::MAX_NODES_DEF,
  parameter int MAX_BRANCH = htlm_pkg::MAX_BRANCH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [htlm_pkg::FUNC_W-1:0]    in_func,
  input  logic [htlm_pkg::NODE_W-1:0]    in_node,
  input  logic [htlm_pkg::USER_W-1:0]    in_user_id,
  output logic                           out_valid,
  output logic                           out_granted,
  input  logic                           cfg_we,
  input  logic [htlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [htlm_pkg::CNT_CFG_W-1:0] cfg_data
);
  import htlm_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int BASE_W = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
  localparam int AW     = BASE_W + BR_CFG_W + 1;
  localparam int WORD_W = USER_W + 1;
  localparam int BR_CAP = (MAX_BRANCH < 31) ? MAX_BRANCH : 31;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  state_t              state_r, state_nxt;
  logic [CNT_CFG_W-1:0] ncount_r;
  logic [BR_CFG_W-1:0]  branch_r;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic [IDX_W-1:0]     n_r, n_nxt;
  logic [USER_W-1:0]    id_r, id_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [AW-1:0]        lo_r, lo_nxt;
  logic [AW-1:0]        hi_r, hi_nxt;
  logic [AW-1:0]        j_r, j_nxt;
  logic                 rel_r, rel_nxt;
  logic                 any_r, any_nxt;
  logic                 scan_vld_r, scan_vld_nxt;
  logic [IDX_W-1:0]     clr_r, clr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_granted_r, out_granted_nxt;

  logic [AW-1:0]        eff_cnt, ncount_ext, cnt_m1, node_ext;
  logic [BR_CFG_W-1:0]  b0, eff_b;
  logic [AW-1:0]        b_ext, lo_lvl, hi_lvl, hi_clamp;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_addr;
  logic [WORD_W-1:0]    mem_wdata, mem_rdata;
  logic                 rd_lock, hit_bad, seen, func_ok;
  logic [USER_W-1:0]    rd_owner;

  logic                 div_start, div_done;
  logic [IDX_W-1:0]     div_q;
  logic                 cfg_hit;

  // Effective tree shape from the registers.
  always_comb begin
    ncount_ext = AW'(ncount_r);
    eff_cnt    = (ncount_ext > AW'(MAX_NODES)) ? AW'(MAX_NODES) : ncount_ext;
    cnt_m1     = eff_cnt - AW'(1);
    b0         = (branch_r == '0) ? BR_CFG_W'(1) : branch_r;
    eff_b      = (b0 > BR_CFG_W'(BR_CAP)) ? BR_CFG_W'(BR_CAP) : b0;
    b_ext      = AW'(eff_b);
    node_ext   = AW'(in_node);
  end

  // Bounds of the next breadth-first level of the subtree.
  always_comb begin
    lo_lvl   = lo_r * b_ext + AW'(1);
    hi_lvl   = hi_r * b_ext + b_ext;
    hi_clamp = (hi_lvl > cnt_m1) ? cnt_m1 : hi_lvl;
  end

  // Check of the descendant word read in the previous cycle.
  always_comb begin
    rd_lock  = mem_rdata[USER_W];
    rd_owner = mem_rdata[USER_W-1:0];
    hit_bad  = scan_vld_r && rd_lock && ((func_r == FUNC_LOCK) || (rd_owner != id_r));
    seen     = any_r || (scan_vld_r && rd_lock);
    func_ok  = (in_func == FUNC_LOCK) || (in_func == FUNC_UNLOCK) ||
               (in_func == FUNC_UPGRADE);
  end

  // Sequencer: next state, memory port and result.
  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    n_nxt           = n_r;
    id_nxt          = id_r;
    cur_nxt         = cur_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    j_nxt           = j_r;
    rel_nxt         = rel_r;
    any_nxt         = any_r;
    scan_vld_nxt    = 1'b0;
    clr_nxt         = clr_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    mem_we          = 1'b0;
    mem_addr        = j_r[IDX_W-1:0];
    mem_wdata       = '0;
    div_start       = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + IDX_W'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          id_nxt   = in_user_id;
          n_nxt    = node_ext[IDX_W-1:0];
          if ((node_ext < eff_cnt) && func_ok) begin
            mem_addr  = node_ext[IDX_W-1:0];
            state_nxt = S_NODE;
          end else begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b0;
          end
        end
      end
      S_NODE: begin
        if (func_r == FUNC_UNLOCK) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (rd_lock && (rd_owner == id_r)) begin
            mem_we          = 1'b1;
            mem_addr        = n_r;
            mem_wdata       = {1'b0, rd_owner};
            out_granted_nxt = 1'b1;
          end else begin
            out_granted_nxt = 1'b0;
          end
        end else if (rd_lock) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
        end else begin
          cur_nxt   = n_r;
          state_nxt = S_ANC;
        end
      end
      S_ANC: begin
        if (cur_r == '0) begin
          lo_nxt    = AW'(n_r);
          hi_nxt    = AW'(n_r);
          rel_nxt   = 1'b0;
          any_nxt   = 1'b0;
          state_nxt = S_LVL;
        end else if (eff_b == BR_CFG_W'(1)) begin
          cur_nxt   = cur_r - IDX_W'(1);
          mem_addr  = cur_r - IDX_W'(1);
          state_nxt = S_ANCD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cur_nxt   = div_q;
          mem_addr  = div_q;
          state_nxt = S_ANCD;
        end
      end
      S_ANCD: begin
        if (rd_lock) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
        end else begin
          state_nxt = S_ANC;
        end
      end
      S_LVL: begin
        any_nxt = seen;
        if (hit_bad) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
        end else if (lo_lvl >= eff_cnt) begin
          if (rel_r || (func_r == FUNC_LOCK)) begin
            mem_we          = 1'b1;
            mem_addr        = n_r;
            mem_wdata       = {1'b1, id_r};
            state_nxt       = S_IDLE;
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b1;
          end else if (!seen) begin
            state_nxt       = S_IDLE;
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b0;
          end else begin
            // Every locked descendant belongs to this user: release them all.
            rel_nxt = 1'b1;
            lo_nxt  = AW'(n_r);
            hi_nxt  = AW'(n_r);
          end
        end else begin
          lo_nxt    = lo_lvl;
          hi_nxt    = hi_clamp;
          j_nxt     = lo_lvl;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        if (rel_r) begin
          mem_we = 1'b1;
        end else begin
          scan_vld_nxt = 1'b1;
          any_nxt      = seen;
        end
        if (j_r == hi_r) begin
          state_nxt = S_LVL;
        end else begin
          j_nxt = j_r + AW'(1);
        end
        if (hit_bad) begin
          scan_vld_nxt    = 1'b0;
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // A write to the node count or branching register restarts the clearing pass.
    if (cfg_we && ((cfg_index == REG_NODE_COUNT) || (cfg_index == REG_BRANCHING))) begin
      state_nxt = S_CLR;
      clr_nxt   = '0;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_r         <= '0;
      ncount_r      <= RESET_NODE_COUNT;
      branch_r      <= RESET_BRANCHING;
      out_valid_r   <= 1'b0;
      out_granted_r <= 1'b0;
      scan_vld_r    <= 1'b0;
      rel_r         <= 1'b0;
      any_r         <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      out_valid_r   <= out_valid_nxt;
      out_granted_r <= out_granted_nxt;
      scan_vld_r    <= scan_vld_nxt;
      rel_r         <= rel_nxt;
      any_r         <= any_nxt;
      if (cfg_we && (cfg_index == REG_NODE_COUNT)) begin
        ncount_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_BRANCHING)) begin
        branch_r <= cfg_data[BR_CFG_W-1:0];
      end
    end
    func_r <= func_nxt;
    n_r    <= n_nxt;
    id_r   <= id_nxt;
    cur_r  <= cur_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    j_r    <= j_nxt;
  end

  // Node store: lock bit over owner.
  htlm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_NODES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // Parent index divider.
  htlm_div #(
    .W(IDX_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(cur_r - IDX_W'(1)),
    .divisor (eff_b),
    .done    (div_done),
    .quotient(div_q)
  );

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;

  // A write to one of the two registers.
  assign cfg_hit = cfg_we && ((cfg_index == REG_NODE_COUNT) || (cfg_index == REG_BRANCHING));

  `HTLM_ASSERT_RST(a_accept_progress, start && !busy |=> busy || out_valid)
  `HTLM_ASSERT_RST(a_scan_bound, state_r == S_SUB |-> j_r <= hi_r)
  `HTLM_ASSERT_RST(a_cfg_clear, cfg_hit |=> state_r == S_CLR)
  `HTLM_ASSERT(a_reset_clear, !rst_n |=> state_r == S_CLR)

endmodule

@@ src/htlm_ram.sv @@
module htlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read of the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/htlm_div.sv @@
module htlm_div #(
  parameter int W = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [W-1:0]                  dividend,
  input  logic [htlm_pkg::BR_CFG_W-1:0] divisor,
  output logic                          done,
  output logic [W-1:0]                  quotient
);
  import htlm_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [W-1:0]      q_r, q_nxt;
  logic [BR_CFG_W-1:0] rem_r, rem_nxt;
  logic [BR_CFG_W-1:0] d_r, d_nxt;
  logic [BR_CFG_W:0]   sh;
  logic [BR_CFG_W:0]   diff;
  logic                ge;

  // One quotient bit per cycle, restoring division.
  always_comb begin
    sh       = {rem_r, q_r[W-1]};
    ge       = (sh >= {1'b0, d_r});
    diff     = sh - {1'b0, d_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[BR_CFG_W-1:0] : sh[BR_CFG_W-1:0];
      q_nxt   = W'({q_r, ge});
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ tb/sv/hierarchical_tree_lock_manager_test.sv @@
`timescale 1ns / 1ps
module hierarchical_tree_lock_manager_test;
  import htlm_pkg::*;

  localparam int TREE_MAX = 1024;
  localparam int BRANCH_MAX = 16;
  localparam int CYCLE_LIMIT = 12000000;
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

  typedef enum int {SUB_FLAG, SUB_CHECK, SUB_CLEAR} subtree_op_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [FUNC_W-1:0] in_func;
  logic [NODE_W-1:0] in_node;
  logic [USER_W-1:0] in_user_id;
  logic out_valid;
  logic out_granted;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_CFG_W-1:0] cfg_data;

  hierarchical_tree_lock_manager dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_node(in_node), .in_user_id(in_user_id),
    .out_valid(out_valid), .out_granted(out_granted),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the lock table and the tree shape.
  bit lock_held[TREE_MAX];
  bit [USER_W-1:0] lock_owner[TREE_MAX];
  bit ancestor_held[TREE_MAX];
  int unsigned held_below[TREE_MAX];
  int unsigned shadow_count;
  int unsigned shadow_branch;

  bit grant_queue[$];
  int err_count;
  int cycle_count = 0;
  bit idle_enabled;
  bit [USER_W-1:0] user_pool[4];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop for a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < TREE_MAX; i++) begin
      lock_held[i] = 1'b0;
      lock_owner[i] = '0;
      ancestor_held[i] = 1'b0;
      held_below[i] = 0;
    end
  endfunction

  function automatic int tree_size();
    return (shadow_count > TREE_MAX) ? TREE_MAX : shadow_count;
  endfunction

  function automatic int tree_fanout();
    if (shadow_branch == 0) return 1;
    return (shadow_branch > BRANCH_MAX) ? BRANCH_MAX : shadow_branch;
  endfunction

  // Count one more (or one fewer) held node on every ancestor of n.
  function automatic void bump_ancestors(int n, bit up);
    int b;
    b = tree_fanout();
    while (n > 0) begin
      n = (n - 1) / b;
      if (up) held_below[n]++;
      else if (held_below[n] > 0) held_below[n]--;
    end
  endfunction

  // Visit the strict descendants of n level by level.
  function automatic bit visit_subtree(int n, subtree_op_t op, bit [USER_W-1:0] id, bit flag);
    longint lo, hi, cnt, b;
    cnt = tree_size();
    b = tree_fanout();
    lo = n;
    hi = n;
    forever begin
      lo = lo * b + 1;
      hi = hi * b + b;
      if (lo >= cnt) break;
      if (hi > cnt - 1) hi = cnt - 1;
      for (longint j = lo; j <= hi; j++) begin
        case (op)
          SUB_FLAG: ancestor_held[j] = flag;
          SUB_CHECK: if (lock_held[j] && lock_owner[j] != id) return 1'b0;
          default: begin
            if (lock_held[j]) begin
              bump_ancestors(int'(j), 1'b0);
              lock_held[j] = 1'b0;
            end
            ancestor_held[j] = 1'b0;
          end
        endcase
      end
    end
    return 1'b1;
  endfunction

  function automatic bit try_lock(int n, bit [USER_W-1:0] id);
    if (lock_held[n] || ancestor_held[n] || held_below[n] != 0) return 1'b0;
    bump_ancestors(n, 1'b1);
    void'(visit_subtree(n, SUB_FLAG, id, 1'b1));
    lock_held[n] = 1'b1;
    lock_owner[n] = id;
    return 1'b1;
  endfunction

  function automatic bit try_unlock(int n, bit [USER_W-1:0] id);
    if (!lock_held[n] || lock_owner[n] != id) return 1'b0;
    bump_ancestors(n, 1'b0);
    void'(visit_subtree(n, SUB_FLAG, id, 1'b0));
    lock_held[n] = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit try_upgrade(int n, bit [USER_W-1:0] id);
    if (lock_held[n] || ancestor_held[n] || held_below[n] == 0) return 1'b0;
    if (!visit_subtree(n, SUB_CHECK, id, 1'b0)) return 1'b0;
    void'(visit_subtree(n, SUB_CLEAR, id, 1'b0));
    return try_lock(n, id);
  endfunction

  function automatic bit predict_grant(logic [FUNC_W-1:0] f, int n, bit [USER_W-1:0] id);
    if (n >= tree_size()) return 1'b0;
    case (f)
      FUNC_LOCK: return try_lock(n, id);
      FUNC_UNLOCK: return try_unlock(n, id);
      FUNC_UPGRADE: return try_upgrade(n, id);
      default: return 1'b0;
    endcase
  endfunction

  // Each result beat is checked against the oldest expected grant.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (grant_queue.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else if (out_granted !== grant_queue[0]) begin
        report_mismatch($sformatf("granted %b, expected %b", out_granted, grant_queue[0]));
        void'(grant_queue.pop_front());
      end else begin
        void'(grant_queue.pop_front());
      end
    end
  end

  // Every task below is entered and left at a falling edge.
  task automatic send_request(input logic [FUNC_W-1:0] f, input int n,
                              input bit [USER_W-1:0] id);
    in_func = f;
    in_node = n[NODE_W-1:0];
    in_user_id = id;
    start = 1'b1;
    while (busy) @(negedge clk);
    grant_queue.insert(grant_queue.size(), predict_grant(f, n % TREE_MAX, id));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (grant_queue.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CNT_CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_NODE_COUNT) begin
      shadow_count = value & 32'h7FF;
      clear_table();
    end else if (idx == REG_BRANCHING) begin
      shadow_branch = value & 32'h1F;
      clear_table();
    end
  endtask

  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  function automatic int find_held();
    int cnt, first, j;
    cnt = tree_size();
    if (cnt == 0) return -1;
    first = $urandom_range(0, cnt - 1);
    for (int k = 0; k < cnt; k++) begin
      j = (first + k) % cnt;
      if (lock_held[j]) return j;
    end
    return -1;
  endfunction

  // Mostly coherent traffic: unlocks aim at held nodes and their owners, upgrades at ancestors of held nodes.
  task automatic random_request();
    int cnt, r, n, j, b;
    bit [USER_W-1:0] id;
    logic [FUNC_W-1:0] f;
    cnt = tree_size();
    b = tree_fanout();
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? $urandom : user_pool[$urandom_range(0, 3)];
    n = (cnt == 0 || $urandom_range(0, 19) == 0) ? $urandom_range(0, TREE_MAX - 1)
                                                   : $urandom_range(0, cnt - 1);
    j = find_held();
    if (r < 35) begin
      f = FUNC_LOCK;
    end else if (r < 60) begin
      f = FUNC_UNLOCK;
      if (j >= 0 && $urandom_range(0, 4) != 0) begin
        n = j;
        id = lock_owner[j];
      end
    end else if (r < 92) begin
      f = FUNC_UPGRADE;
      if (j > 0 && $urandom_range(0, 4) != 0) begin
        n = j;
        repeat ($urandom_range(1, 3)) if (n > 0) n = (n - 1) / b;
        if ($urandom_range(0, 4) != 0) id = lock_owner[j];
      end
    end else begin
      f = ($urandom_range(0, 1) != 0) ? FUNC_RESERVED : FUNC_LOCK;
    end
    maybe_idle();
    send_request(f, n, id);
  endtask

  // Lock, conflict, unlock and upgrade on the reset tree shape.
  task automatic test_basic_ops();
    send_request(FUNC_LOCK, 0, user_pool[0]);
    send_request(FUNC_LOCK, 1, user_pool[1]);
    send_request(FUNC_UNLOCK, 0, user_pool[1]);
    send_request(FUNC_UNLOCK, 0, user_pool[0]);
    send_request(FUNC_LOCK, 3, user_pool[0]);
    send_request(FUNC_LOCK, 4, user_pool[0]);
    send_request(FUNC_LOCK, 1, user_pool[0]);
    send_request(FUNC_UPGRADE, 1, user_pool[0]);
    send_request(FUNC_UPGRADE, 0, user_pool[2]);
    send_request(FUNC_UPGRADE, 2, user_pool[0]);
    send_request(FUNC_RESERVED, 5, user_pool[0]);
    send_request(FUNC_LOCK, 1023, 32'hFFFF_FFFF);
    send_request(FUNC_UNLOCK, 1023, 32'h0000_0000);
    send_request(FUNC_UNLOCK, 1023, 32'hFFFF_FFFF);
  endtask

  // Register extremes: empty tree, clamped sizes, a plain chain, unused indexes.
  task automatic test_register_extremes();
    write_reg(REG_NODE_COUNT, 0);
    send_request(FUNC_LOCK, 0, user_pool[0]);
    write_reg(REG_NODE_COUNT, 5);
    send_request(FUNC_LOCK, 5, user_pool[0]);
    send_request(FUNC_LOCK, 4, user_pool[0]);
    write_reg(REG_UNUSED, 11'h7FF);
    send_request(FUNC_LOCK, 4, user_pool[0]);
    write_reg(REG_UNUSED_HI, 0);
    write_reg(REG_BRANCHING, 0);
    write_reg(REG_NODE_COUNT, 2047);
    send_request(FUNC_LOCK, 1023, user_pool[1]);
    send_request(FUNC_UPGRADE, 0, user_pool[1]);
    write_reg(REG_BRANCHING, 11'h7FF);
    send_request(FUNC_LOCK, 17, user_pool[2]);
    send_request(FUNC_UPGRADE, 1, user_pool[2]);
  endtask

  task automatic test_random_traffic();
    int counts[9] = '{16, 31, 64, 200, 7, 40, 50, 1024, 1500};
    int fans[9] = '{2, 3, 4, 16, 1, 0, 31, 2, 8};
    int items[9] = '{70, 70, 70, 70, 60, 60, 70, 43, 43};
    for (int p = 0; p < 9; p++) begin
      write_reg(REG_NODE_COUNT, counts[p]);
      write_reg(REG_BRANCHING, fans[p] | ($urandom_range(0, 63) << 5));
      idle_enabled = (p < 7);
      for (int i = 0; i < items[p]; i++) begin
        random_request();
        if (p == 2 && i == 30) wait_drained();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_LOCK;
    in_node = '0;
    in_user_id = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_data = '0;
    err_count = 0;
    idle_enabled = 1'b1;
    user_pool = '{32'd1, 32'd2, 32'h8000_0000, 32'hFFFF_FFFF};
    shadow_count = RESET_NODE_COUNT;
    shadow_branch = RESET_BRANCHING;
    clear_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_register_extremes();
    test_random_traffic();

    wait_drained();
    repeat (50) @(negedge clk);
    if (err_count == 0 && grant_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ hierarchical_tree_lock_manager.f @@
+incdir+src
src/htlm_pkg.sv
src/htlm_ram.sv
src/htlm_div.sv
src/hierarchical_tree_lock_manager.sv
tb/sv/hierarchical_tree_lock_manager_test.sv
